// ===== design/pps_pkg.sv =====
// Shared constants for the protected power switch sequencer.
// Channel count, timer widths, mode and opcode codes, bus widths.
// No dependencies.
`default_nettype none
package pps_pkg;

  // channel count and time base
  localparam int CHANNELS      = 2;
  localparam int MS_PER_SECOND = 1000;
  localparam int LINES         = 2;

  // field widths
  localparam int OP_W      = 2;
  localparam int CHAN_W    = 4;
  localparam int SECS_W    = 16;
  localparam int DELAY_W   = 16;
  localparam int ELAPSED_W = 26;
  localparam int MODE_W    = 2;

  // stream widths (tdata padded to whole bytes)
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 8;

  localparam logic [DELAY_W-1:0]   DELAY_RESET = 16'd2000;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};
  localparam logic [ELAPSED_W-1:0] MS_SCALE    = ELAPSED_W'(MS_PER_SECOND);
  localparam logic [CHAN_W:0]      CHAN_LIMIT  = (CHAN_W+1)'(CHANNELS);

  // channel modes
  localparam logic [MODE_W-1:0] MODE_OFF         = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DISARMING   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ON          = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TURNING_OFF = 2'd3;

  // opcodes
  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_ON   = 2'd1;
  localparam logic [OP_W-1:0] OP_OFF  = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

endpackage
`default_nettype wire

// ===== design/protected_power_switch_sequencer_core.sv =====
// Protected power switch sequencer: top level with per-channel sequencers.
// Depends on pps_pkg.
//
// Usage:
//   Slave stream carries one word per command: tuser holds the opcode
//   (tick, turn-on, turn-off), tdata holds the channel and the on time in
//   seconds. A tick stands for one elapsed millisecond on every channel.
//   Master stream returns one word per command with the protection lines,
//   the power lines and the ignored flag, all taken after the update.
//   The delay register is written through cfg_wr_en / cfg_wr_data. The user
//   must write it only while the block is idle; the block does not enforce it.
//   Path: an accepted word is held in the input register, then moves into
//   the result register, where it drives m_axis_tvalid until it is taken.
//   Throughput: one word per cycle unless the master side stalls; every channel
//   updates in parallel in the single pass between the input and result registers.
//   Reset: all channels go to off with timers cleared, the delay register
//   takes 2000 ms, both stages empty.
//   Stall: while the master side is stalled the result holds, the input
//   register holds one more word, and only then does s_axis_tready drop.
`default_nettype none
module protected_power_switch_sequencer_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration: protection_delay_ms
  input  wire logic                           cfg_wr_en,
  input  wire logic [pps_pkg::DELAY_W-1:0]    cfg_wr_data,
  // command stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: [3:0] channel, [19:4] on_time_s, [23:20] zero
  input  wire logic [pps_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // tuser: [1:0] opcode
  input  wire logic [pps_pkg::OP_W-1:0]       s_axis_tuser,
  // status stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // tdata: [1:0] protection_lines, [3:2] power_lines, [4] ignored, [7:5] zero
  output logic [pps_pkg::M_TDATA_W-1:0]       m_axis_tdata
);
  import pps_pkg::*;

  logic                  in_valid;
  logic [OP_W-1:0]       in_op;
  logic [CHAN_W-1:0]     in_chan;
  logic [SECS_W-1:0]     in_secs;
  logic                  res_valid;
  logic [M_TDATA_W-1:0]  res_data;
  logic [DELAY_W-1:0]    delay_ms;
  logic                  advance;
  logic                  fire;

  logic [MODE_W-1:0]     mode       [CHANNELS];
  logic [MODE_W-1:0]     mode_next  [CHANNELS];
  logic [ELAPSED_W-1:0]  held_ms    [CHANNELS];
  logic [ELAPSED_W-1:0]  held_ms_next [CHANNELS];
  logic [ELAPSED_W-1:0]  elapsed    [CHANNELS];
  logic [ELAPSED_W-1:0]  elapsed_next [CHANNELS];

  logic [ELAPSED_W-1:0]  on_limit_ms;
  logic                  ignored;
  logic [LINES-1:0]      prot_lines;
  logic [LINES-1:0]      pwr_lines;

  // handshake: result moves on when empty or taken, input when it can drain
  assign advance       = !res_valid || m_axis_tready;
  assign fire          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = res_data;

  // hold the delay register
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ms <= DELAY_RESET;
    end else if (cfg_wr_en) begin
      delay_ms <= cfg_wr_data;
    end
  end

  // capture the incoming word
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op   <= s_axis_tuser;
      in_chan <= s_axis_tdata[CHAN_W-1:0];
      in_secs <= s_axis_tdata[CHAN_W+SECS_W-1:CHAN_W];
    end
  end

  // on time in milliseconds, stored at the request so ticks only compare
  assign on_limit_ms = ELAPSED_W'(in_secs) * MS_SCALE;

  // flag requests aimed past the last channel
  assign ignored = ((in_op == OP_ON) || (in_op == OP_OFF)) &&
                   ({1'b0, in_chan} >= CHAN_LIMIT);

  // per-channel sequencer update
  always_comb begin
    logic [ELAPSED_W-1:0] e_inc;
    logic [ELAPSED_W-1:0] limit;
    logic                 hit;
    for (int c = 0; c < CHANNELS; c++) begin
      mode_next[c]    = mode[c];
      held_ms_next[c] = held_ms[c];
      elapsed_next[c] = elapsed[c];
      hit   = (in_chan == CHAN_W'(c));
      e_inc = (elapsed[c] == ELAPSED_MAX) ? elapsed[c] : elapsed[c] + 1'b1;
      limit = (mode[c] == MODE_ON) ? held_ms[c] : ELAPSED_W'(delay_ms);
      unique case (in_op)
        OP_TICK: begin
          if (mode[c] != MODE_OFF) begin
            if (e_inc > limit) begin
              elapsed_next[c] = '0;
              unique case (mode[c])
                MODE_DISARMING: mode_next[c] = MODE_ON;
                MODE_ON:        mode_next[c] = MODE_TURNING_OFF;
                default:        mode_next[c] = MODE_OFF;
              endcase
            end else begin
              elapsed_next[c] = e_inc;
            end
          end
        end
        OP_ON: begin
          if (hit) begin
            if ((mode[c] == MODE_OFF) || (mode[c] == MODE_TURNING_OFF)) begin
              mode_next[c] = MODE_DISARMING;
            end
            held_ms_next[c] = on_limit_ms;
            elapsed_next[c] = '0;
          end
        end
        OP_OFF: begin
          if (hit) begin
            if (mode[c] == MODE_ON) begin
              mode_next[c]    = MODE_TURNING_OFF;
              elapsed_next[c] = '0;
            end else if (mode[c] == MODE_DISARMING) begin
              mode_next[c]    = MODE_OFF;
              elapsed_next[c] = '0;
            end
          end
        end
        OP_NONE: begin
        end
      endcase
    end
  end

  // derive the lines from the updated modes
  always_comb begin
    for (int l = 0; l < LINES; l++) begin
      if (l < CHANNELS) begin
        prot_lines[l] = (mode_next[l] != MODE_OFF);
        pwr_lines[l]  = (mode_next[l] == MODE_ON);
      end else begin
        prot_lines[l] = 1'b0;
        pwr_lines[l]  = 1'b0;
      end
    end
  end

  // advance channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        mode[c]    <= MODE_OFF;
        held_ms[c] <= '0;
        elapsed[c] <= '0;
      end
    end else if (fire) begin
      for (int c = 0; c < CHANNELS; c++) begin
        mode[c]    <= mode_next[c];
        held_ms[c] <= held_ms_next[c];
        elapsed[c] <= elapsed_next[c];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_data <= M_TDATA_W'({ignored, pwr_lines, prot_lines});
    end
  end

endmodule
`default_nettype wire

// ===== design/pps_checker.sv =====
// Port-level checker for the protected power switch sequencer.
// Depends on pps_pkg; bound to protected_power_switch_sequencer_core.
`default_nettype none
module pps_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [pps_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import pps_pkg::*;

  // power applied only where protection is disarmed
  a_power_needs_disarm: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((m_axis_tdata[3:2] & ~m_axis_tdata[1:0]) == 2'b00))
    else $error("power line set on an armed channel");

  // drop both stages at reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && s_axis_tready))
    else $error("pipeline not empty after reset");

  // hold a stalled word
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // refuse input only while a result is stalled
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input refused without a stalled result");

endmodule

bind protected_power_switch_sequencer_core pps_checker u_pps_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ===== tb/protected_power_switch_sequencer_core_test.sv =====
// Self-checking testbench for the protected power switch sequencer core.
// Predicts status words from the commands accepted and checks each word received.
// Depends on pps_pkg and protected_power_switch_sequencer_core.
`default_nettype none
module protected_power_switch_sequencer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pps_pkg::*;

  // status word fields, highest first so that the packing matches m_axis_tdata
  typedef struct packed {
    logic             ignored;
    logic [LINES-1:0] power_lines;
    logic [LINES-1:0] protection_lines;
  } status_t;

  // Tracks every channel sequencer and holds the status words still due
  class switch_tracker;
    logic [MODE_W-1:0]    mode    [CHANNELS];
    logic [SECS_W-1:0]    held_s  [CHANNELS];
    logic [ELAPSED_W-1:0] elapsed [CHANNELS];
    logic [DELAY_W-1:0]   delay_ms;
    status_t              status_due[$];
    int                   fails;
    int                   words_seen;

    function new();
      delay_ms = DELAY_RESET;
      fails = 0;
      words_seen = 0;
      for (int c = 0; c < CHANNELS; c++) begin
        mode[c] = MODE_OFF;
        held_s[c] = '0;
        elapsed[c] = '0;
      end
    endfunction

    // one millisecond on a single channel
    function void advance(int c);
      logic [31:0] lim;
      if (mode[c] == MODE_OFF) return;
      if (elapsed[c] != ELAPSED_MAX) elapsed[c] = elapsed[c] + 1'b1;
      if (mode[c] == MODE_ON) lim = 32'(held_s[c]) * 32'(MS_PER_SECOND);
      else lim = 32'(delay_ms);
      if (32'(elapsed[c]) > lim) begin
        elapsed[c] = '0;
        case (mode[c])
          MODE_DISARMING: mode[c] = MODE_ON;
          MODE_ON:        mode[c] = MODE_TURNING_OFF;
          default:        mode[c] = MODE_OFF;
        endcase
      end
    endfunction

    // apply an accepted command and queue the status word it produces
    function void take_command(logic [OP_W-1:0] op, logic [CHAN_W-1:0] ch,
                               logic [SECS_W-1:0] secs);
      status_t s;
      int      idx;
      s = '0;
      idx = int'(ch);
      if (op == OP_TICK) begin
        for (int c = 0; c < CHANNELS; c++) advance(c);
      end else if (op == OP_ON || op == OP_OFF) begin
        if (idx >= CHANNELS) begin
          s.ignored = 1'b1;
        end else if (op == OP_ON) begin
          if (mode[idx] == MODE_OFF || mode[idx] == MODE_TURNING_OFF)
            mode[idx] = MODE_DISARMING;
          held_s[idx] = secs;
          elapsed[idx] = '0;
        end else if (mode[idx] == MODE_ON) begin
          mode[idx] = MODE_TURNING_OFF;
          elapsed[idx] = '0;
        end else if (mode[idx] == MODE_DISARMING) begin
          mode[idx] = MODE_OFF;
          elapsed[idx] = '0;
        end
      end
      for (int c = 0; c < CHANNELS && c < LINES; c++) begin
        s.protection_lines[c] = (mode[c] != MODE_OFF);
        s.power_lines[c] = (mode[c] == MODE_ON);
      end
      status_due.push_back(s);
    endfunction

    // compare a received word with the oldest one due
    function void check_status(logic [M_TDATA_W-1:0] word);
      status_t got;
      status_t want;
      got = status_t'(word[4:0]);
      words_seen++;
      if (status_due.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("status word %0d arrived with nothing due: %b", words_seen, word);
        return;
      end
      want = status_due.pop_front();
      if (got.protection_lines !== want.protection_lines ||
          got.power_lines !== want.power_lines || got.ignored !== want.ignored) begin
        fails++;
        if (fails <= 10)
          $display("status word %0d: protection exp %b got %b, power exp %b got %b, %s %b got %b",
                   words_seen, want.protection_lines, got.protection_lines,
                   want.power_lines, got.power_lines, "ignored exp",
                   want.ignored, got.ignored);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [DELAY_W-1:0]   cfg_wr_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [OP_W-1:0]      s_axis_tuser = OP_TICK;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  switch_tracker tracker = new();
  int            burst_left = 0;
  bit            bulk_started = 1'b0;
  bit            long_hold_done = 1'b0;

  protected_power_switch_sequencer_core uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk = ~clk;

  // Check every status word as it is taken
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) tracker.check_status(m_axis_tdata);
  end

  // Offer one command word in bursts with random gaps, hold until accepted
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [CHAN_W-1:0] ch,
                          input logic [SECS_W-1:0] secs);
    if (burst_left == 0) begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = op;
    s_axis_tdata = {4'b0000, secs, ch};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    tracker.take_command(op, ch, secs);
  endtask

  // Drop the stream and wait until every status word due has come back
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (tracker.status_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_delay(input logic [DELAY_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    tracker.delay_ms = value;
    burst_left = 0;
  endtask

  // Mostly ticks with on and off requests mixed in, now and then a stray channel
  task automatic random_phase(input int count);
    int                pick;
    logic [OP_W-1:0]   op;
    logic [CHAN_W-1:0] ch;
    logic [SECS_W-1:0] secs;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 66) op = OP_TICK;
      else if (pick < 80) op = OP_ON;
      else if (pick < 92) op = OP_OFF;
      else op = OP_NONE;
      if (op == OP_TICK || op == OP_NONE) begin
        ch = CHAN_W'($urandom);
        secs = SECS_W'($urandom);
      end else begin
        ch = ($urandom_range(0, 99) < 85) ? CHAN_W'($urandom_range(0, CHANNELS - 1))
                                          : CHAN_W'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 55) secs = '0;
        else if (pick < 70) secs = SECS_W'($urandom_range(1, 2));
        else secs = SECS_W'($urandom_range(0, 65535));
      end
      send_cmd(op, ch, secs);
    end
  endtask

  // Receiver: ready in runs, random toggling or short stalls, one long hold-off
  initial begin
    int kind;
    int len;
    forever begin
      if (bulk_started && !long_hold_done) begin
        long_hold_done = 1'b1;
        repeat (96) begin
          @(negedge clk);
          m_axis_tready = 1'b0;
        end
      end
      kind = $urandom_range(0, 2);
      len = $urandom_range(1, 40);
      if (kind == 2) len = $urandom_range(1, 6);
      repeat (len) begin
        @(negedge clk);
        case (kind)
          0:       m_axis_tready = 1'b1;
          1:       m_axis_tready = 1'($urandom_range(0, 1));
          default: m_axis_tready = 1'b0;
        endcase
      end
    end
  end

  // Stimulus
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // default delay: request paths, stray channels, unused opcode
    send_cmd(OP_TICK, 4'd0, 16'd0);
    send_cmd(OP_ON, 4'd0, 16'hFFFF);
    send_cmd(OP_ON, 4'd1, 16'd0);
    send_cmd(OP_TICK, 4'd0, 16'd0);
    send_cmd(OP_ON, 4'd15, 16'h1234);
    send_cmd(OP_OFF, 4'd2, 16'd0);
    send_cmd(OP_NONE, 4'd0, 16'hFFFF);
    send_cmd(OP_TICK, 4'd15, 16'hFFFF);
    send_cmd(OP_ON, 4'd0, 16'd5);
    send_cmd(OP_OFF, 4'd0, 16'd0);
    send_cmd(OP_OFF, 4'd0, 16'd0);
    send_cmd(OP_OFF, 4'd1, 16'd0);

    // zero delay: walk both channels through every mode
    write_delay(16'd0);
    send_cmd(OP_ON, 4'd0, 16'd0);
    send_cmd(OP_ON, 4'd1, 16'd0);
    send_cmd(OP_TICK, 4'd0, 16'd0);
    send_cmd(OP_OFF, 4'd1, 16'd0);
    send_cmd(OP_ON, 4'd1, 16'd0);
    send_cmd(OP_TICK, 4'd0, 16'd0);
    send_cmd(OP_ON, 4'd0, 16'd3);
    send_cmd(OP_TICK, 4'd0, 16'd0);
    send_cmd(OP_ON, 4'd0, 16'd9);
    send_cmd(OP_TICK, 4'd0, 16'd0);
    send_cmd(OP_OFF, 4'd0, 16'd0);
    send_cmd(OP_OFF, 4'd0, 16'd0);
    send_cmd(OP_TICK, 4'd0, 16'd0);

    // random traffic under several delay settings
    bulk_started = 1'b1;
    random_phase(192);
    write_delay(16'd1);
    random_phase(192);
    write_delay(16'd3);
    random_phase(192);
    write_delay(16'hFFFF);
    random_phase(192);
    write_delay(DELAY_W'($urandom_range(2, 10)));
    random_phase(192);
    write_delay(16'd0);
    random_phase(192);

    drain();
    repeat (4) @(posedge clk);
    tracker.fails += tracker.status_due.size();
    if (tracker.fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire
